[hdl/selective_repeat_receive_window_top_macros.svh]
// Assertion macros for the selective-repeat receive window.
// Used by the core module; expects clk and rst_n in the enclosing scope.
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_TOP_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SRRW_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srrw: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define SRRW_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srrw: next-cycle check failed");

`endif

[hdl/srrw_pkg.sv]
// Shared widths, reset values and beat types for the receive window.
// No dependencies; used by every module of the block.
package srrw_pkg;

  localparam int SEQ_W       = 32;  // sequence number width
  localparam int MASK_W      = 32;  // selective-ack mask width
  localparam int MASK_IDX_W  = 5;   // bit index into the mask
  localparam int WSIZE_W     = 6;   // window size register width
  localparam int MAX_WINDOW  = 32;  // largest effective window
  localparam int CNT_W       = 6;   // trailing-ones count / advance width

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 6'd32;
  localparam logic [SEQ_W-1:0]   BASE_RESET  = 32'd1;

  // Beat held in the input register
  typedef struct packed {
    logic             valid;
    logic [SEQ_W-1:0] seq_num;
  } item_t;

  // Result beat from the core to the output register
  typedef struct packed {
    logic              valid;
    logic [SEQ_W-1:0]  ack_seq;
    logic [MASK_W-1:0] rx_bitmap;
  } result_t;

endpackage

[hdl/srrw_in_reg.sv]
// Input register stage: captures one sequence-number beat.
// Depends on srrw_pkg.
module srrw_in_reg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [srrw_pkg::SEQ_W-1:0]   in_seq_num,
  input  logic                         take,
  output srrw_pkg::item_t              item
);

  logic                       valid_r;
  logic                       valid_nxt;
  logic [srrw_pkg::SEQ_W-1:0] seq_r;
  logic                       load;

  // register refills when empty or when the core consumes it
  assign load      = !valid_r || take;
  assign in_stall  = !load;
  assign valid_nxt = load ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      seq_r <= in_seq_num;
    end
  end

  assign item.valid   = valid_r;
  assign item.seq_num = seq_r;

endmodule

[hdl/srrw_core.sv]
// Window state, window size register and per-beat classification/update.
// Depends on srrw_pkg and selective_repeat_receive_window_top_macros.svh.
`include "selective_repeat_receive_window_top_macros.svh"

module srrw_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [srrw_pkg::WSIZE_W-1:0]  cfg_wr_data,
  input  srrw_pkg::item_t               item,
  input  logic                          out_free,
  output logic                          take,
  output srrw_pkg::result_t             res
);

  localparam int SW = srrw_pkg::SEQ_W;
  localparam int MW = srrw_pkg::MASK_W;
  localparam int CW = srrw_pkg::CNT_W;
  localparam int WW = srrw_pkg::WSIZE_W;
  localparam int IW = srrw_pkg::MASK_IDX_W;

  logic [WW-1:0] wsize_r;
  logic [SW-1:0] base_r;
  logic [SW-1:0] base_nxt;
  logic [MW-1:0] mask_r;
  logic [MW-1:0] mask_nxt;

  logic [WW-1:0] weff;
  logic [SW:0]   limit;
  logic [SW:0]   seq_x;
  logic [SW:0]   base_x;
  logic          drop;
  logic          at_base;
  logic          in_win;
  logic [CW-1:0] ones_cnt;
  logic [CW-1:0] adv;
  logic [SW-1:0] adv_base;
  logic [MW-1:0] adv_mask;
  logic [SW-1:0] offset;
  logic [IW-1:0] bit_idx;
  logic [MW-1:0] set_mask;
  logic          upd;

  // effective window: size saturated into 1..MAX_WINDOW
  always_comb begin
    weff = wsize_r;
    if (wsize_r == '0) begin
      weff = {{(WW-1){1'b0}}, 1'b1};
    end else if (wsize_r > WW'(srrw_pkg::MAX_WINDOW)) begin
      weff = WW'(srrw_pkg::MAX_WINDOW);
    end
  end

  // 33-bit compares against base and base+W
  assign seq_x   = {1'b0, item.seq_num};
  assign base_x  = {1'b0, base_r};
  assign limit   = base_x + {{(SW+1-WW){1'b0}}, weff};
  assign drop    = seq_x > limit;
  assign at_base = item.seq_num == base_r;
  assign in_win  = (seq_x > base_x) && (seq_x < limit);

  // trailing ones of the mask: priority encoder on the lowest zero bit
  always_comb begin
    ones_cnt = CW'(MW);
    for (int i = MW - 1; i >= 0; i--) begin
      if (!mask_r[i]) begin
        ones_cnt = CW'(i);
      end
    end
  end

  // base advance past the received run
  assign adv      = ones_cnt + {{(CW-1){1'b0}}, 1'b1};
  assign adv_base = base_r + {{(SW-CW){1'b0}}, adv};
  assign adv_mask = (adv >= CW'(MW)) ? '0 : (mask_r >> adv);

  // in-window receive: set bit (seq - base - 1)
  assign offset   = item.seq_num - base_r;
  assign bit_idx  = offset[IW-1:0] - {{(IW-1){1'b0}}, 1'b1};
  assign set_mask = mask_r | ({{(MW-1){1'b0}}, 1'b1} << bit_idx);

  // dropped beats retire without needing output room
  assign take = item.valid && (drop || out_free);
  assign upd  = take && !drop;

  always_comb begin
    base_nxt = base_r;
    mask_nxt = mask_r;
    if (upd && at_base) begin
      base_nxt = adv_base;
      mask_nxt = adv_mask;
    end else if (upd && in_win) begin
      mask_nxt = set_mask;
    end
  end

  // result beat
  always_comb begin
    res.valid     = upd;
    res.ack_seq   = base_r;
    res.rx_bitmap = mask_r;
    if (at_base) begin
      res.ack_seq   = adv_base;
      res.rx_bitmap = adv_mask;
    end else if (in_win) begin
      res.ack_seq   = item.seq_num;
      res.rx_bitmap = set_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r <= srrw_pkg::WSIZE_RESET;
      base_r  <= srrw_pkg::BASE_RESET;
      mask_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        wsize_r <= cfg_wr_data;
      end
      base_r <= base_nxt;
      mask_r <= mask_nxt;
    end
  end

  // base holds unless a beat is retired
  `SRRW_ASSERT_NXT(a_base_hold, rst_n && !take, $stable(base_r))
  // an at-base beat always moves the base
  `SRRW_ASSERT_NXT(a_base_moves, rst_n && upd && at_base, base_r != $past(base_r))
  // an in-window beat only adds mask bits
  `SRRW_ASSERT_NXT(a_mask_grows, rst_n && upd && in_win, (mask_r & $past(mask_r)) == $past(mask_r))
  // a result is only produced when the output register has room
  `SRRW_ASSERT_IMP(a_res_room, res.valid, out_free && !drop)

endmodule

[hdl/srrw_out_reg.sv]
// Output register stage: holds one ack beat until the sink takes it.
// Depends on srrw_pkg.
module srrw_out_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srrw_pkg::result_t             res,
  output logic                          out_free,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [srrw_pkg::SEQ_W-1:0]    out_ack_seq,
  output logic [srrw_pkg::MASK_W-1:0]   out_rx_bitmap
);

  logic                        valid_r;
  logic                        valid_nxt;
  logic [srrw_pkg::SEQ_W-1:0]  ack_r;
  logic [srrw_pkg::MASK_W-1:0] sack_r;

  // room when empty or draining this cycle
  assign out_free  = !valid_r || !out_stall;
  assign valid_nxt = out_free ? res.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (res.valid) begin
      ack_r  <= res.ack_seq;
      sack_r <= res.rx_bitmap;
    end
  end

  assign out_valid     = valid_r;
  assign out_ack_seq   = ack_r;
  assign out_rx_bitmap = sack_r;

endmodule

[hdl/selective_repeat_receive_window_top.sv]
// Top level of the selective-repeat receive window.
// Depends on srrw_pkg, srrw_in_reg, srrw_core and srrw_out_reg.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   in      | in_valid, in_stall, in_seq_num[31:0]          | sink
//   out     | out_valid, out_stall, out_ack_seq[31:0],      | source
//           | out_rx_bitmap[31:0]                           |
//   cfg     | cfg_wr_en, cfg_wr_data[5:0] (window size)     | sink
//
// One beat per cycle sustained while out_stall is low; an accepted beat reaches out_valid
// through the input register, then classify/update into the output register.
// The window state is written as each beat retires, so consecutive beats see each other.
// Synchronous active-low reset: base 1, mask 0, window size 32, both stages empty.
// Dropped beats retire even while out_stall is high; other beats wait in the
// input register until the output register has room.
module selective_repeat_receive_window_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [srrw_pkg::WSIZE_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [srrw_pkg::SEQ_W-1:0]    in_seq_num,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [srrw_pkg::SEQ_W-1:0]    out_ack_seq,
  output logic [srrw_pkg::MASK_W-1:0]   out_rx_bitmap
);

  srrw_pkg::item_t   item;
  srrw_pkg::result_t res;
  logic              take;
  logic              out_free;

  srrw_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_seq_num (in_seq_num),
    .take       (take),
    .item       (item)
  );

  srrw_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .out_free    (out_free),
    .take        (take),
    .res         (res)
  );

  srrw_out_reg u_out_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .res           (res),
    .out_free      (out_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ack_seq   (out_ack_seq),
    .out_rx_bitmap (out_rx_bitmap)
  );

endmodule
